[rtl/assert_macros.svh]
// Assertion macros for the NMEA RMC time extractor checkers.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while in reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, also active during reset
`define ASSERT_CLK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/nmea_rmc_pkg.sv]
// Shared types and constants for the NMEA RMC local-time extractor.
// No dependencies.
package nmea_rmc_pkg;

  localparam int BUFFER_LEN = 16;
  localparam int CNT_W      = $clog2(BUFFER_LEN + 1);
  localparam int BYTE_W     = 8;
  localparam int NIB_W      = 4;
  localparam int DIGITS     = 4;
  localparam int DIG_IDX_W  = $clog2(DIGITS);
  localparam int TZ_W       = 4;
  localparam int HOUR_W     = 8;
  localparam int LAST_W     = 1 + 3 * NIB_W;

  localparam int APB_AW = 2;
  localparam int APB_DW = 32;

  localparam logic [APB_AW-1:0] REG_TZ_ADDR = '0;
  localparam logic [TZ_W-1:0]   TZ_RESET    = 4'd5;

  localparam logic [CNT_W-1:0] CNT_FULL      = CNT_W'(BUFFER_LEN);
  localparam logic [CNT_W-1:0] CNT_DIGITS    = CNT_W'(DIGITS);
  localparam logic [CNT_W-1:0] SHORT_MAX_CNT = CNT_W'(7);

  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
  localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
  localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
  localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_C      = 8'h43;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_A      = 8'h41;

  localparam logic [HOUR_W-1:0] HOUR_FOLD = 8'd12;
  localparam logic [HOUR_W:0]   HOUR_TEN  = 9'd10;

  localparam logic             SHORT_HT  = 1'b1;
  localparam logic [NIB_W-1:0] SHORT_NIB = 4'd9;

  typedef logic [NIB_W-1:0] nib_t;

  typedef enum logic [3:0] {
    PH_LF,
    PH_DOLLAR,
    PH_G,
    PH_P,
    PH_R,
    PH_M,
    PH_C,
    PH_COMMA,
    PH_COLLECT,
    PH_DROP
  } phase_t;

  typedef struct packed {
    nib_t [DIGITS-1:0] nib;
    logic              fix_valid;
    logic              short_field;
  } cap_t;

endpackage

[rtl/nmea_rmc_cfg.sv]
// APB register file: time-zone offset register.
// Depends on nmea_rmc_pkg.
module nmea_rmc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [nmea_rmc_pkg::APB_AW-1:0]    paddr,
  input  logic [nmea_rmc_pkg::APB_DW-1:0]    pwdata,
  output logic [nmea_rmc_pkg::APB_DW-1:0]    prdata,
  output logic                               pready,
  output logic [nmea_rmc_pkg::TZ_W-1:0]      tz_offset
);
  import nmea_rmc_pkg::*;

  logic [TZ_W-1:0] tz_r, tz_nxt;
  logic            wr_tz;

  assign wr_tz  = psel && penable && pwrite && (paddr == REG_TZ_ADDR);
  assign tz_nxt = wr_tz ? pwdata[TZ_W-1:0] : tz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tz_r <= TZ_RESET;
    end else begin
      tz_r <= tz_nxt;
    end
  end

  assign prdata    = (paddr == REG_TZ_ADDR) ? APB_DW'(tz_r) : '0;
  assign pready    = 1'b1;
  assign tz_offset = tz_r;

endmodule

[rtl/nmea_rmc_parse.sv]
// Sentence matcher and field capture; holds one finished capture word.
// Depends on nmea_rmc_pkg.
module nmea_rmc_parse (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [nmea_rmc_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                              cap_valid,
  input  logic                              cap_ready,
  output nmea_rmc_pkg::cap_t                cap
);
  import nmea_rmc_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              comma_r, comma_nxt;
  logic              pend_r, pend_nxt;
  logic              isa_r, isa_nxt;
  nib_t [DIGITS-1:0] nib_r, nib_nxt;
  logic              cap_valid_r, cap_valid_nxt;
  cap_t              cap_r, cap_nxt;

  logic acc, emit, is_comma;

  assign in_ready = !cap_valid_r || cap_ready;
  assign acc      = in_valid && in_ready;
  assign is_comma = (in_rx_byte == CH_COMMA);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    comma_nxt = comma_r;
    pend_nxt  = pend_r;
    isa_nxt   = isa_r;
    nib_nxt   = nib_r;
    emit      = 1'b0;
    if (acc) begin
      unique case (phase_r)
        PH_LF:     if (in_rx_byte == CH_LF) phase_nxt = PH_DOLLAR;
        PH_DOLLAR: phase_nxt = (in_rx_byte == CH_DOLLAR) ? PH_G : PH_LF;
        PH_G:      phase_nxt = (in_rx_byte == CH_G) ? PH_P : PH_LF;
        PH_P:      phase_nxt = (in_rx_byte == CH_P) ? PH_R : PH_LF;
        PH_R:      phase_nxt = (in_rx_byte == CH_R) ? PH_M : PH_LF;
        PH_M:      phase_nxt = (in_rx_byte == CH_M) ? PH_C : PH_LF;
        PH_C:      phase_nxt = (in_rx_byte == CH_C) ? PH_COMMA : PH_LF;
        PH_COMMA: begin
          cnt_nxt   = '0;
          comma_nxt = 1'b0;
          pend_nxt  = 1'b0;
          isa_nxt   = 1'b0;
          phase_nxt = is_comma ? PH_COLLECT : PH_LF;
        end
        PH_COLLECT: begin
          if (comma_r && is_comma) begin
            emit      = 1'b1;
            cnt_nxt   = '0;
            comma_nxt = 1'b0;
            pend_nxt  = 1'b0;
            isa_nxt   = 1'b0;
            phase_nxt = PH_DROP;
          end else begin
            if (is_comma) comma_nxt = 1'b1;
            if (cnt_r < CNT_FULL) begin
              if (cnt_r < CNT_DIGITS) nib_nxt[cnt_r[DIG_IDX_W-1:0]] = in_rx_byte[NIB_W-1:0];
              if (is_comma) begin
                pend_nxt = 1'b1;
              end else if (pend_r) begin
                isa_nxt  = (in_rx_byte == CH_A);
                pend_nxt = 1'b0;
              end
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end
        default: phase_nxt = PH_LF;
      endcase
    end
  end

  always_comb begin
    cap_nxt.nib         = nib_r;
    cap_nxt.fix_valid   = isa_r && !pend_r;
    cap_nxt.short_field = (cnt_r <= SHORT_MAX_CNT);
    cap_valid_nxt       = in_ready ? emit : cap_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LF;
      cnt_r       <= '0;
      comma_r     <= 1'b0;
      pend_r      <= 1'b0;
      isa_r       <= 1'b0;
      cap_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      comma_r     <= comma_nxt;
      pend_r      <= pend_nxt;
      isa_r       <= isa_nxt;
      cap_valid_r <= cap_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nib_r <= nib_nxt;
    if (emit) cap_r <= cap_nxt;
  end

  assign cap_valid = cap_valid_r;
  assign cap       = cap_r;

endmodule

[rtl/nmea_rmc_time.sv]
// Local 12-hour time digits, change flag and output register.
// Depends on nmea_rmc_pkg.
module nmea_rmc_time (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cap_valid,
  output logic                              cap_ready,
  input  nmea_rmc_pkg::cap_t                cap,
  input  logic [nmea_rmc_pkg::TZ_W-1:0]     tz_offset,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hour_tens,
  output logic [nmea_rmc_pkg::NIB_W-1:0]    out_hour_ones,
  output logic [nmea_rmc_pkg::NIB_W-1:0]    out_minute_tens,
  output logic [nmea_rmc_pkg::NIB_W-1:0]    out_minute_ones,
  output logic                              out_fix_valid,
  output logic                              out_short_field,
  output logic                              out_changed
);
  import nmea_rmc_pkg::*;

  logic [HOUR_W-1:0] h_utc, h_fold, h_adj;
  logic [HOUR_W:0]   h_loc, h_sub;
  logic              ht_calc;
  nib_t              ho_calc;

  logic              ht_d;
  nib_t              ho_d, mt_d, mo_d;
  logic [LAST_W-1:0] now_d;

  logic              out_valid_r, out_valid_nxt;
  logic [LAST_W-1:0] last_r, last_nxt;
  logic              load;

  logic              ht_r;
  nib_t              ho_r, mt_r, mo_r;
  logic              fix_r, short_r, chg_r;

  // hour = 10*tens + ones, fold to 12h, shift by zone; wraps negative
  always_comb begin
    h_utc   = HOUR_W'({cap.nib[0], 3'b000}) + HOUR_W'({cap.nib[0], 1'b0})
            + HOUR_W'(cap.nib[1]);
    h_fold  = (h_utc > HOUR_FOLD) ? h_utc - HOUR_FOLD : h_utc;
    h_adj   = (h_fold <= HOUR_W'(tz_offset)) ? h_fold + HOUR_FOLD : h_fold;
    h_loc   = (HOUR_W + 1)'(h_adj) - (HOUR_W + 1)'(tz_offset);
    ht_calc = (h_loc >= HOUR_TEN);
    h_sub   = h_loc - HOUR_TEN;
    ho_calc = ht_calc ? h_sub[NIB_W-1:0] : h_loc[NIB_W-1:0];
  end

  always_comb begin
    if (cap.short_field) begin
      ht_d = SHORT_HT;
      ho_d = SHORT_NIB;
      mt_d = SHORT_NIB;
      mo_d = SHORT_NIB;
    end else begin
      ht_d = ht_calc;
      ho_d = ho_calc;
      mt_d = cap.nib[2];
      mo_d = cap.nib[3];
    end
    now_d = {ht_d, ho_d, mt_d, mo_d};
  end

  assign cap_ready     = !out_valid_r || out_ready;
  assign load          = cap_valid && cap_ready;
  assign out_valid_nxt = cap_ready ? cap_valid : out_valid_r;
  assign last_nxt      = load ? now_d : last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ht_r    <= ht_d;
      ho_r    <= ho_d;
      mt_r    <= mt_d;
      mo_r    <= mo_d;
      fix_r   <= cap.fix_valid;
      short_r <= cap.short_field;
      chg_r   <= (now_d != last_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hour_tens   = ht_r;
  assign out_hour_ones   = ho_r;
  assign out_minute_tens = mt_r;
  assign out_minute_ones = mo_r;
  assign out_fix_valid   = fix_r;
  assign out_short_field = short_r;
  assign out_changed     = chg_r;

endmodule

[rtl/nmea_rmc_local_time_extract_top.sv]
// Top level of the NMEA RMC local-time extractor.
// Depends on nmea_rmc_pkg, nmea_rmc_cfg, nmea_rmc_parse, nmea_rmc_time.
//
// Takes one NMEA byte per clock. After a line feed and "$GPRMC," it captures
// the following field bytes; the second comma of the capture produces one
// result word through the parser and output registers, carrying the local
// 12-hour time digits, the fix flag, the short-field flag and a changed flag.
// These two registers form a two-stage pipeline, so a byte is accepted every
// cycle while a result waits; in_ready drops only when both stages hold a
// word and out_ready is low. The time-zone offset (reset 5) is at APB address
// 0 and is to be written only while no result is in flight.
module nmea_rmc_local_time_extract_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nmea_rmc_pkg::APB_AW-1:0]   paddr,
  input  logic [nmea_rmc_pkg::APB_DW-1:0]   pwdata,
  output logic [nmea_rmc_pkg::APB_DW-1:0]   prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [nmea_rmc_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hour_tens,
  output logic [nmea_rmc_pkg::NIB_W-1:0]    out_hour_ones,
  output logic [nmea_rmc_pkg::NIB_W-1:0]    out_minute_tens,
  output logic [nmea_rmc_pkg::NIB_W-1:0]    out_minute_ones,
  output logic                              out_fix_valid,
  output logic                              out_short_field,
  output logic                              out_changed
);
  import nmea_rmc_pkg::*;

  logic [TZ_W-1:0] tz;
  logic            cap_valid, cap_ready;
  cap_t            cap;

  nmea_rmc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .tz_offset (tz)
  );

  nmea_rmc_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .cap_valid  (cap_valid),
    .cap_ready  (cap_ready),
    .cap        (cap)
  );

  nmea_rmc_time u_time (
    .clk             (clk),
    .rst_n           (rst_n),
    .cap_valid       (cap_valid),
    .cap_ready       (cap_ready),
    .cap             (cap),
    .tz_offset       (tz),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hour_tens   (out_hour_tens),
    .out_hour_ones   (out_hour_ones),
    .out_minute_tens (out_minute_tens),
    .out_minute_ones (out_minute_ones),
    .out_fix_valid   (out_fix_valid),
    .out_short_field (out_short_field),
    .out_changed     (out_changed)
  );

endmodule

[rtl/nmea_rmc_chk.sv]
// Port-level checker for the NMEA RMC local-time extractor, with bind.
// Depends on nmea_rmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nmea_rmc_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [nmea_rmc_pkg::BYTE_W-1:0]   in_rx_byte,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_hour_tens,
  input logic [nmea_rmc_pkg::NIB_W-1:0]    out_hour_ones,
  input logic [nmea_rmc_pkg::NIB_W-1:0]    out_minute_tens,
  input logic [nmea_rmc_pkg::NIB_W-1:0]    out_minute_ones,
  input logic                              out_short_field
);
  import nmea_rmc_pkg::*;

  `ASSERT_CLK_RST(a_rst_empty, !rst_n |=> !out_valid, "output word after reset")

  `ASSERT_CLK(a_short_digits, out_valid && out_short_field |-> out_hour_tens == SHORT_HT && out_hour_ones == SHORT_NIB && out_minute_tens == SHORT_NIB && out_minute_ones == SHORT_NIB, "short field digits not 1999")

  // a fresh word on an empty output comes from an accepted comma, via the parser register
  `ASSERT_CLK(a_word_from_comma, in_valid && in_ready && in_rx_byte != CH_COMMA |-> ##2 !$rose(out_valid), "output word without closing comma")

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_hour_ones) && $stable(out_minute_tens) && $stable(out_minute_ones), "stalled output word changed")

endmodule

bind nmea_rmc_local_time_extract_top nmea_rmc_chk u_chk (.*);

[tb/tb.sv]
// Testbench for nmea_rmc_local_time_extract_top: feeds NMEA byte streams, models the RMC
// capture and time folding, and checks every time word in order against that model.
// Depends on nmea_rmc_pkg and the extractor RTL.
module tb;
  import nmea_rmc_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_BYTES  = 270;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic             hour_tens;
    logic [NIB_W-1:0] hour_ones;
    logic [NIB_W-1:0] minute_tens;
    logic [NIB_W-1:0] minute_ones;
    logic             fix_valid;
    logic             short_field;
    logic             changed;
  } time_word_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_rx_byte  = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic              out_hour_tens;
  logic [NIB_W-1:0]  out_hour_ones;
  logic [NIB_W-1:0]  out_minute_tens;
  logic [NIB_W-1:0]  out_minute_ones;
  logic              out_fix_valid;
  logic              out_short_field;
  logic              out_changed;

  logic [BYTE_W-1:0] nmea_bytes[$];
  logic [BYTE_W-1:0] last_field[$];
  time_word_t        time_words[$];
  int                send_idle = 27;
  int                recv_idle = 58;
  int                n_err     = 0;
  int                cycles    = 0;

  // parser model state
  phase_t            ph          = PH_LF;
  int unsigned       cap_cnt     = 0;
  logic              comma_seen  = 1'b0;
  logic              stat_pend   = 1'b0;
  logic              stat_a      = 1'b0;
  logic [NIB_W-1:0]  nib [DIGITS] = '{default: '0};
  logic [15:0]       last_digits = '0;
  logic [TZ_W-1:0]   tz          = TZ_RESET;

  nmea_rmc_local_time_extract_top DUT (.*);

  initial forever #2 clk = ~clk;

  task automatic clear_capture();
    cap_cnt    = 0;
    comma_seen = 1'b0;
    stat_pend  = 1'b0;
    stat_a     = 1'b0;
  endtask

  task automatic predict_time(input logic [BYTE_W-1:0] b);
    time_word_t  w;
    int unsigned h;
    logic [15:0] digits;
    case (ph)
      PH_LF:     if (b == CH_LF) ph = PH_DOLLAR;
      PH_DOLLAR: ph = (b == CH_DOLLAR) ? PH_G : PH_LF;
      PH_G:      ph = (b == CH_G) ? PH_P : PH_LF;
      PH_P:      ph = (b == CH_P) ? PH_R : PH_LF;
      PH_R:      ph = (b == CH_R) ? PH_M : PH_LF;
      PH_M:      ph = (b == CH_M) ? PH_C : PH_LF;
      PH_C:      ph = (b == CH_C) ? PH_COMMA : PH_LF;
      PH_COMMA: begin
        clear_capture();
        ph = (b == CH_COMMA) ? PH_COLLECT : PH_LF;
      end
      PH_COLLECT: begin
        if (!(comma_seen && b == CH_COMMA)) begin
          if (b == CH_COMMA) comma_seen = 1'b1;
          if (cap_cnt < BUFFER_LEN) begin
            if (cap_cnt < DIGITS) nib[cap_cnt] = b[NIB_W-1:0];
            if (b == CH_COMMA) begin
              stat_pend = 1'b1;
            end else if (stat_pend) begin
              stat_a    = (b == CH_A);
              stat_pend = 1'b0;
            end
            cap_cnt++;
          end
        end else begin
          w.fix_valid   = stat_a && !stat_pend;
          w.short_field = (cap_cnt <= SHORT_MAX_CNT);
          if (w.short_field) begin
            w.hour_tens   = SHORT_HT;
            w.hour_ones   = SHORT_NIB;
            w.minute_tens = SHORT_NIB;
            w.minute_ones = SHORT_NIB;
          end else begin
            h = nib[0] * 10 + nib[1];
            if (h > 12) h = h - 12;
            if (h <= tz) h = h + 12;
            h = (h - tz) & 32'hFFFF;
            w.hour_tens = (h > 9);
            if (h > 9) h = (h - 10) & 32'hFFFF;
            w.hour_ones   = NIB_W'(h);
            w.minute_tens = nib[2];
            w.minute_ones = nib[3];
          end
          digits = {3'b000, w.hour_tens, w.hour_ones, w.minute_tens, w.minute_ones};
          w.changed   = (digits != last_digits);
          last_digits = digits;
          time_words.push_back(w);
          clear_capture();
          ph = PH_DROP;
        end
      end
      default: ph = PH_LF;
    endcase
  endtask

  task automatic check_field(input string name, input logic [NIB_W-1:0] exp_v,
                             input logic [NIB_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      n_err++;
    end
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) nmea_bytes.push_back(BYTE_W'(s[i]));
  endtask

  task automatic rmc_line(input string fld, input string st);
    push_str({"\n$GPRMC,", fld, ",", st, ",*"});
  endtask

  task automatic load_directed();
    rmc_line("123519", "A");
    rmc_line("000000", "V");              // star after the closing comma is dropped
    push_str("\n\n$GPRMC,050000,A,*");     // second LF breaks the header
    rmc_line("050000", "A");
    rmc_line("050000", "A");              // same digits again
    rmc_line("1234", "A");                // short field
    push_str("\n$GPRMC,,,*");              // capture ends right after first comma
    push_str("\n$GPRMX,235959,A,\n$GPRMC;1,2,");
    rmc_line("235959.00", "V");
    push_str("\n$GPRMC,");                // overflow, first comma not stored
    for (int i = 0; i < 20; i++) nmea_bytes.push_back((i % 2) ? 8'h00 : 8'hFF);
    push_str(",A,*");
    rmc_line("123456789012345", "A");     // first comma lands in last slot
  endtask

  task automatic gen_sentence();
    logic [BYTE_W-1:0] fld[$];
    logic [BYTE_W-1:0] hdr[$];
    string             s;
    int unsigned       r;
    int unsigned       n;
    r = $urandom_range(99);
    if (r < 8) begin
      n = $urandom_range(1, 8);
      repeat (n) nmea_bytes.push_back(BYTE_W'($urandom_range(255)));
      return;
    end
    if (r < 25 && last_field.size() != 0) begin
      fld = last_field;
    end else if (r < 75) begin
      s = $sformatf("%02d%02d%02d", $urandom_range(23), $urandom_range(59),
                    $urandom_range(59));
      if ($urandom_range(1)) s = {s, ".00"};
      for (int i = 0; i < s.len(); i++) fld.push_back(BYTE_W'(s[i]));
    end else if (r < 88) begin
      n = $urandom_range(0, 20);
      repeat (n) fld.push_back(BYTE_W'($urandom_range(255)));
    end else begin
      n = $urandom_range(0, 7);
      repeat (n) fld.push_back(BYTE_W'(8'h30 + $urandom_range(9)));
    end
    last_field = fld;
    s = "\n$GPRMC,";
    for (int i = 0; i < s.len(); i++) hdr.push_back(BYTE_W'(s[i]));
    if ($urandom_range(99) < 8) hdr[$urandom_range(7)] = BYTE_W'($urandom_range(255));
    foreach (hdr[i]) nmea_bytes.push_back(hdr[i]);
    foreach (fld[i]) nmea_bytes.push_back(fld[i]);
    nmea_bytes.push_back(CH_COMMA);
    r = $urandom_range(99);
    if (r < 45)      nmea_bytes.push_back(CH_A);
    else if (r < 80) nmea_bytes.push_back(BYTE_W'("V"));
    else if (r >= 90) nmea_bytes.push_back(BYTE_W'($urandom_range(255)));
    if ($urandom_range(99) < 95) nmea_bytes.push_back(CH_COMMA);
    n = $urandom_range(0, 3);
    repeat (n) nmea_bytes.push_back(BYTE_W'($urandom_range(255)));
  endtask

  task automatic drain();
    while (nmea_bytes.size() != 0 || in_valid || time_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tz(input logic [TZ_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_TZ_ADDR;
    pwdata  <= APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_ready) begin
        if (nmea_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_rx_byte <= nmea_bytes.pop_front();
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    time_word_t w;
    if (rst_n) begin
      if (in_valid && in_ready) predict_time(in_rx_byte);
      if (psel && penable && pwrite && pready && paddr == REG_TZ_ADDR)
        tz = pwdata[TZ_W-1:0];
      if (out_valid && out_ready) begin
        if (time_words.size() == 0) begin
          $error("time word with none expected");
          n_err++;
        end else begin
          w = time_words.pop_front();
          check_field("hour_tens", w.hour_tens, out_hour_tens);
          check_field("hour_ones", w.hour_ones, out_hour_ones);
          check_field("minute_tens", w.minute_tens, out_minute_tens);
          check_field("minute_ones", w.minute_ones, out_minute_ones);
          check_field("fix_valid", w.fix_valid, out_fix_valid);
          check_field("short_field", w.short_field, out_short_field);
          check_field("changed", w.changed, out_changed);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [TZ_W-1:0] tz_set [6] = '{4'd0, 4'd11, 4'd7, 4'd1, 4'd10, 4'd3};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    load_directed();
    drain();
    for (int p = 0; p < 6; p++) begin
      send_idle = (p < 2) ? 27 : (p < 4) ? 58 : 0;
      recv_idle = (p < 2) ? 58 : (p < 4) ? 27 : 0;
      write_tz(tz_set[p]);
      while (nmea_bytes.size() < PHASE_BYTES) gen_sentence();
      drain();
    end
    repeat (20) @(posedge clk);
    if (n_err == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
